[rtl/wnr_pkg.sv]
// Shared constants and types for the width-w NAF scalar recoder.
package wnr_pkg;

	localparam int CHUNK_BITS    = 32;
	localparam int MAX_WINDOW    = 7;
	localparam int MAX_POSITIONS = 1024;

	localparam int W_W       = 3;
	localparam int DIG_W     = 7;
	localparam int POS_W     = 11;
	localparam int MASK_W    = 32;
	localparam int PEND_W    = 16;
	localparam int CNT_W     = 4;
	localparam int SKIP_W    = 3;
	localparam int BIT_IDX_W = $clog2(CHUNK_BITS);
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	// digit transfers per chunk; one slot is kept for the summary
	localparam int STEP_DIGITS = 19;
	localparam int STEP_CNT_W  = 5;

	// register indexes
	localparam logic [ADDR_W-3:0] REG_WINDOW_WIDTH = '0;

	localparam logic [W_W-1:0] WINDOW_RESET = W_W'(4);
	localparam logic [W_W-1:0] WINDOW_MIN   = W_W'(2);

	typedef struct packed {
		logic [CHUNK_BITS-1:0] scalar_chunk;
		logic                  chunk_last;
	} in_item_t;

	typedef struct packed {
		logic signed [DIG_W-1:0] digit;
		logic [POS_W-1:0]        position;
		logic                    digit_valid;
		logic                    run_last;
		logic [POS_W-1:0]        digit_length;
		logic [MASK_W-1:0]       used_mask;
		logic                    overflow;
	} out_item_t;

	// sequencer -> recoding unit
	typedef struct packed {
		logic insert;
		logic bit_in;
		logic decide;
		logic clear;
	} wnr_ctrl_t;

	// recoding unit -> sequencer
	typedef struct packed {
		logic [CNT_W-1:0]        cnt;
		logic                    pend_nz;
		logic                    emit;
		logic signed [DIG_W-1:0] digit;
		logic [POS_W-1:0]        position;
		logic [POS_W-1:0]        length;
		logic [MASK_W-1:0]       mask;
		logic                    ovf;
	} wnr_stat_t;

endpackage

[rtl/wnaf_scalar_recoder.sv]
// Top level of the width-w NAF scalar recoder: sequencer, config register, output stage.
//
//  channel  | handshake         | payload                   | direction
//  ---------+-------------------+---------------------------+----------
//  in       | in_valid/in_stall | in_data  (in_item_t)      | into block
//  out      | out_valid/out_st. | out_data (out_item_t)     | out of block
//  cfg      | APB psel/penable  | paddr/pwdata/prdata       | both
//
// A chunk is shifted in one bit per cycle, while the output is not stalled, after
// the accept cycle. Each scan cycle inserts one bit and decides one NAF position
// once w bits are held. If the window was narrowed between chunks, a decide-only
// step runs for each held bit beyond w-1. The last chunk adds a flush decide for
// each position until the residual is zero, then a check that sees it empty and
// a summary transfer.
// Reset is asynchronous, active low; no clearing pass is needed after it.
// A stall on the output pauses the whole sequencer; input is taken only when idle.
module wnaf_scalar_recoder (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  wnr_pkg::in_item_t             in_data,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output wnr_pkg::out_item_t            out_data,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wnr_pkg::ADDR_W-1:0]    paddr,
	input  logic [wnr_pkg::DATA_W-1:0]    pwdata,
	output logic [wnr_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_SUM   = 4'b1000
	} state_t;

	state_t                              st_q;
	logic [wnr_pkg::CHUNK_BITS-1:0]      sh_q;
	logic                                last_q;
	logic [wnr_pkg::BIT_IDX_W-1:0]       bit_cnt_q;
	logic [wnr_pkg::W_W-1:0]             win_q;
	logic [wnr_pkg::W_W-1:0]             w_eff;
	logic                                out_valid_q;
	wnr_pkg::out_item_t                  out_q;
	logic [wnr_pkg::STEP_CNT_W-1:0]      step_dig_q;

	wnr_pkg::wnr_ctrl_t                  ctrl;
	wnr_pkg::wnr_stat_t                  stat;

	logic adv;        // sequencer may take a step this cycle
	logic in_xfer;
	logic cfg_wr;
	logic reg_hit;
	logic win_full;   // enough bits held to decide without a new one
	logic emit_now;
	logic dig_out;    // digit goes out as a transfer

	// ---------------- configuration ----------------
	assign pready  = 1'b1;
	assign reg_hit = (paddr[wnr_pkg::ADDR_W-1:2] == wnr_pkg::REG_WINDOW_WIDTH);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? wnr_pkg::DATA_W'(win_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= wnr_pkg::WINDOW_RESET;
		end else if (cfg_wr) begin
			win_q <= pwdata[wnr_pkg::W_W-1:0];
		end
	end

	// clamp window to the supported range
	always_comb begin
		priority if (win_q < wnr_pkg::WINDOW_MIN) begin
			w_eff = wnr_pkg::WINDOW_MIN;
		end else if (win_q > wnr_pkg::W_W'(wnr_pkg::MAX_WINDOW)) begin
			w_eff = wnr_pkg::W_W'(wnr_pkg::MAX_WINDOW);
		end else begin
			w_eff = win_q;
		end
	end

	// ---------------- sequencer ----------------
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = (st_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign win_full = (stat.cnt >= wnr_pkg::CNT_W'(w_eff));

	always_comb begin
		ctrl = '0;
		unique case (st_q)
			ST_IDLE: begin
			end
			ST_RUN: begin
				if (adv) begin
					if (win_full) begin
						// window narrowed since last chunk: drain surplus first
						ctrl.decide = 1'b1;
					end else begin
						ctrl.insert = 1'b1;
						ctrl.bit_in = sh_q[0];
						ctrl.decide = ((stat.cnt + wnr_pkg::CNT_W'(1)) >=
							wnr_pkg::CNT_W'(w_eff));
					end
				end
			end
			ST_FLUSH: begin
				ctrl.decide = adv && stat.pend_nz;
			end
			ST_SUM: begin
				ctrl.clear = adv;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			bit_cnt_q <= '0;
			last_q    <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (in_xfer) begin
						st_q      <= ST_RUN;
						bit_cnt_q <= '0;
						last_q    <= in_data.chunk_last;
					end
				end
				ST_RUN: begin
					if (ctrl.insert) begin
						bit_cnt_q <= bit_cnt_q + wnr_pkg::BIT_IDX_W'(1);
						if (bit_cnt_q == wnr_pkg::BIT_IDX_W'(wnr_pkg::CHUNK_BITS - 1)) begin
							st_q <= last_q ? ST_FLUSH : ST_IDLE;
						end
					end
				end
				ST_FLUSH: begin
					if (adv && !stat.pend_nz) begin
						st_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (adv) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// chunk shift register, one bit consumed per insert
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sh_q <= in_data.scalar_chunk;
		end else if (ctrl.insert) begin
			sh_q <= sh_q >> 1;
		end
	end

	wnr_digit_unit u_digit (
		.clk    (clk),
		.arst_n (arst_n),
		.w      (w_eff),
		.ctrl   (ctrl),
		.stat   (stat)
	);

	// ---------------- output stage ----------------
	// digits past the per-chunk cap still count toward length and mask,
	// they just do not go out
	assign dig_out  = stat.emit &&
		(step_dig_q < wnr_pkg::STEP_CNT_W'(wnr_pkg::STEP_DIGITS));
	assign emit_now = dig_out || ctrl.clear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_dig_q <= '0;
		end else if (in_xfer) begin
			step_dig_q <= '0;
		end else if (dig_out) begin
			step_dig_q <= step_dig_q + wnr_pkg::STEP_CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_now) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			// summary transfer for the finished scalar
			out_q.digit        <= '0;
			out_q.position     <= '0;
			out_q.digit_valid  <= 1'b0;
			out_q.run_last     <= 1'b1;
			out_q.digit_length <= stat.length;
			out_q.used_mask    <= stat.mask;
			out_q.overflow     <= stat.ovf;
		end else if (dig_out) begin
			out_q.digit        <= stat.digit;
			out_q.position     <= stat.position;
			out_q.digit_valid  <= 1'b1;
			out_q.run_last     <= 1'b0;
			out_q.digit_length <= '0;
			out_q.used_mask    <= '0;
			out_q.overflow     <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[rtl/wnr_digit_unit.sv]
// Recoding state and decide step: one bit in, one position out per cycle when stepped.
module wnr_digit_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [wnr_pkg::W_W-1:0]   w,
	input  wnr_pkg::wnr_ctrl_t        ctrl,
	output wnr_pkg::wnr_stat_t        stat
);

	logic [wnr_pkg::PEND_W-1:0]  pend_q;
	logic [wnr_pkg::CNT_W-1:0]   cnt_q;
	logic [wnr_pkg::SKIP_W-1:0]  skip_q;
	logic [wnr_pkg::POS_W-1:0]   np_q;
	logic [wnr_pkg::POS_W-1:0]   len_q;
	logic [wnr_pkg::MASK_W-1:0]  mask_q;
	logic                        ovf_q;

	logic [wnr_pkg::PEND_W-1:0]  v1, v2, v3, full, low, half, u, mag, dv;
	logic [wnr_pkg::CNT_W-1:0]   cnt1, cnt_n;
	logic [wnr_pkg::SKIP_W-1:0]  skip_n;
	logic [wnr_pkg::POS_W:0]     abs_pos;
	logic                        neg, digit_ev, emit, ovf_set;

	always_comb begin
		abs_pos = {1'b0, np_q} + (wnr_pkg::POS_W+1)'(cnt_q);
		ovf_set = ctrl.insert && ctrl.bit_in &&
			(abs_pos >= (wnr_pkg::POS_W+1)'(wnr_pkg::MAX_POSITIONS));

		v1   = ctrl.insert ? pend_q + (wnr_pkg::PEND_W'(ctrl.bit_in) << cnt_q) : pend_q;
		cnt1 = ctrl.insert ? cnt_q + wnr_pkg::CNT_W'(1) : cnt_q;

		full = wnr_pkg::PEND_W'(1) << w;
		low  = full - wnr_pkg::PEND_W'(1);
		half = full >> 1;
		u    = v1 & low;
		neg  = (u >= half);
		mag  = neg ? full - u : u;
		dv   = u - (neg ? full : '0);

		digit_ev = ctrl.decide && (skip_q == '0) && v1[0];
		emit     = digit_ev && (np_q <= wnr_pkg::POS_W'(wnr_pkg::MAX_POSITIONS));

		v2 = digit_ev ? (v1 & ~low) + (neg ? full : '0) : v1;
		v3 = ctrl.decide ? (v2 >> 1) : v1;

		if (!ctrl.decide) begin
			skip_n = skip_q;
		end else if (skip_q != '0) begin
			skip_n = skip_q - wnr_pkg::SKIP_W'(1);
		end else if (digit_ev) begin
			skip_n = w - wnr_pkg::SKIP_W'(1);
		end else begin
			skip_n = '0;
		end

		if (ctrl.decide && cnt1 != '0) begin
			cnt_n = cnt1 - wnr_pkg::CNT_W'(1);
		end else begin
			cnt_n = cnt1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= '0;
			skip_q <= '0;
			np_q   <= '0;
			len_q  <= '0;
			mask_q <= '0;
			ovf_q  <= 1'b0;
		end else if (ctrl.clear) begin
			pend_q <= '0;
			cnt_q  <= '0;
			skip_q <= '0;
			np_q   <= '0;
			len_q  <= '0;
			mask_q <= '0;
			ovf_q  <= 1'b0;
		end else begin
			pend_q <= v3;
			cnt_q  <= cnt_n;
			skip_q <= skip_n;
			// position saturates; anything past the limit is dropped anyway
			if (ctrl.decide && np_q != '1) begin
				np_q <= np_q + wnr_pkg::POS_W'(1);
			end
			if (emit) begin
				len_q  <= np_q + wnr_pkg::POS_W'(1);
				mask_q <= mask_q | (wnr_pkg::MASK_W'(1) << mag[5:1]);
			end
			if (ovf_set) begin
				ovf_q <= 1'b1;
			end
		end
	end

	assign stat.cnt      = cnt_q;
	assign stat.pend_nz  = (pend_q != '0);
	assign stat.emit     = emit;
	assign stat.digit    = $signed(dv[wnr_pkg::DIG_W-1:0]);
	assign stat.position = np_q;
	assign stat.length   = len_q;
	assign stat.mask     = mask_q;
	assign stat.ovf      = ovf_q;

endmodule

[rtl/wnr_checker.sv]
// Port-level checks for the NAF recoder, bound to the top level.
module wnr_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  wnr_pkg::out_item_t            out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output changed under stall");

	// a chunk takes many cycles, so input closes right after a transfer
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after a chunk transfer");

	// digit transfers carry an odd digit and no summary fields
	a_digit_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.digit_valid |->
			out_data.digit[0] && !out_data.run_last && out_data.digit_length == '0 &&
			out_data.used_mask == '0 && !out_data.overflow)
		else $error("malformed digit transfer");

	// summary transfers close the run and carry no digit
	a_sum_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.digit_valid |->
			out_data.run_last && out_data.digit == '0 && out_data.position == '0)
		else $error("malformed summary transfer");

endmodule

bind wnaf_scalar_recoder wnr_checker u_wnr_checker (.*);

[tb/sv/naf_check_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard for the NAF recoder: bit-level digit predictor and result checking.
package naf_check_pkg;
	import wnr_pkg::*;

	localparam int DIGITS_PER_CHUNK = 19;	// one slot kept free for the summary
	localparam int POS_SATURATE     = 65535;

	class naf_digit_scoreboard;
		logic [W_W-1:0]    window_reg;
		logic [63:0]       residual;
		int unsigned       held_bits;
		int unsigned       zero_run;
		int unsigned       scan_pos;
		int unsigned       digit_span;
		logic [MASK_W-1:0] magnitudes;
		bit                scalar_ovf;
		int                chunk_digits;
		out_item_t         expected_digits[$];
		int                errors;

		function new();
			window_reg = WINDOW_RESET;
			errors = 0;
			clear_scalar();
		endfunction

		function void clear_scalar();
			residual = '0;
			held_bits = 0;
			zero_run = 0;
			scan_pos = 0;
			digit_span = 0;
			magnitudes = '0;
			scalar_ovf = 0;
		endfunction

		function void set_window(logic [W_W-1:0] value);
			window_reg = value;
		endfunction

		function int unsigned active_width();
			if (window_reg < WINDOW_MIN) return WINDOW_MIN;
			if (window_reg > MAX_WINDOW) return MAX_WINDOW;
			return window_reg;
		endfunction

		function int pending();
			return expected_digits.size();
		endfunction

		// decide the digit at the bottom of the residual, then shift by one
		function void decide_position();
			int unsigned w;
			logic [63:0] span, low_bits, u, mag;
			bit neg;
			out_item_t r;
			w = active_width();
			span = 64'd1 << w;
			low_bits = span - 64'd1;
			if (zero_run > 0) begin
				zero_run--;
			end else if (residual[0]) begin
				u = residual & low_bits;
				neg = (u >= (span >> 1));
				mag = neg ? span - u : u;
				if (scan_pos <= MAX_POSITIONS) begin
					if (chunk_digits < DIGITS_PER_CHUNK) begin
						r = '0;
						r.digit = DIG_W'(neg ? 64'd0 - mag : mag);
						r.position = POS_W'(scan_pos);
						r.digit_valid = 1'b1;
						expected_digits.push_back(r);
						chunk_digits++;
					end
					digit_span = scan_pos + 1;
					magnitudes |= MASK_W'(1) << ((mag >> 1) & 64'd31);
				end
				residual = (residual & ~low_bits) + (neg ? span : 64'd0);
				zero_run = w - 1;
			end
			residual >>= 1;
			if (held_bits > 0) held_bits--;
			if (scan_pos < POS_SATURATE) scan_pos++;
		endfunction

		function void absorb_chunk(in_item_t c);
			out_item_t r;
			chunk_digits = 0;
			for (int i = 0; i < CHUNK_BITS; i++) begin
				if (c.scalar_chunk[i] && scan_pos + held_bits >= MAX_POSITIONS) scalar_ovf = 1;
				residual += 64'(c.scalar_chunk[i]) << held_bits;
				held_bits++;
				while (held_bits >= active_width()) decide_position();
			end
			if (c.chunk_last) begin
				while (residual != 0) decide_position();
				r = '0;
				r.run_last = 1'b1;
				r.digit_length = POS_W'(digit_span);
				r.used_mask = magnitudes;
				r.overflow = scalar_ovf;
				expected_digits.push_back(r);
				clear_scalar();
			end
		endfunction

		function void compare_field(string field, longint want_v, longint got_v);
			if (want_v != got_v) begin
				$error("%s: expected %0d, got %0d", field, want_v, got_v);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_digits.size() == 0) begin
				$error("unexpected result: digit %0d position %0d run_last %0b",
					$signed(got.digit), got.position, got.run_last);
				errors++;
				return;
			end
			want = expected_digits.pop_front();
			compare_field("digit", $signed(want.digit), $signed(got.digit));
			compare_field("position", want.position, got.position);
			compare_field("digit_valid", want.digit_valid, got.digit_valid);
			compare_field("run_last", want.run_last, got.run_last);
			compare_field("digit_length", want.digit_length, got.digit_length);
			compare_field("used_mask", want.used_mask, got.used_mask);
			compare_field("overflow", want.overflow, got.overflow);
		endfunction
	endclass

endpackage

[tb/sv/tb_wnaf_scalar_recoder.sv]
`timescale 1ns / 100ps
// Top-level testbench for the width-w NAF scalar recoder.
module tb_wnaf_scalar_recoder;
	import wnr_pkg::*;
	import naf_check_pkg::*;

	// No transfer on either channel for this long means the block is hung.
	// Worst legit quiet stretch is the long output hold or a settle wait.
	localparam int STALL_LIMIT   = 3000;
	// This covers one chunk's scan plus surplus decides after narrowing and the
	// flush of the last chunk, with margin.
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES   = 400;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	in_item_t          in_data  = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_item_t         out_data;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [DATA_W-1:0] pwdata   = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	naf_digit_scoreboard naf_board = new();

	bit calm;               // both sides skip their random waits
	bit hold_off_request;   // asks the receiver for one long stall
	int idle_cycles = 0;

	wnaf_scalar_recoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #1 clk = ~clk;

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Transfer monitor: every accepted chunk feeds the predictor, every
	// accepted result is checked against the oldest expectation.
	// Also the watchdog: counts edges without any transfer.
	always @(posedge clk) begin
		if (in_valid && !in_stall) naf_board.absorb_chunk(in_data);
		if (out_valid && !out_stall) naf_board.check_result(out_data);
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: random stall before each result, one long hold on request.
	initial begin : receiver
		int unsigned wait_n;
		@(posedge arst_n);
		forever begin
			if (hold_off_request) begin
				hold_off_request = 0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			wait_n = calm ? 0 : $urandom_range(0, 16);
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offer one chunk after a random gap; returns at the accepting edge with
	// in_valid still high so back-to-back chunks need no extra edge.
	task automatic send_chunk(logic [CHUNK_BITS-1:0] bits, bit last);
		int unsigned gap;
		in_item_t item;
		gap = calm ? 0 : $urandom_range(0, 16);
		item.scalar_chunk = bits;
		item.chunk_last = last;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
	endtask

	// Sender pauses until every expected result is back, then lets the
	// block finish any chunk that produced nothing further.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (naf_board.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write of the window register, then read it back.
	task automatic write_window(logic [W_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_WINDOW_WIDTH, 2'b00};
		pwdata <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);         // write lands here
		naf_board.set_window(value);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== DATA_W'(value)) begin
			$error("window_width readback: expected %0d, got %0d", value, prdata);
			naf_board.errors++;
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mix of dense, sparse, all-ones and zero chunks to vary carry behavior.
	function automatic logic [CHUNK_BITS-1:0] chunk_pattern();
		case ($urandom_range(0, 9))
			5: return '1;
			6: return '0;
			7: return CHUNK_BITS'(1) << $urandom_range(0, CHUNK_BITS - 1);
			8: return $urandom & $urandom;
			9: return ~(CHUNK_BITS'(1) << $urandom_range(0, CHUNK_BITS - 1));
			default: return $urandom;
		endcase
	endfunction

	// One scalar of random chunks; optionally retunes the window mid scalar
	// once the block has gone idle between two chunks.
	task automatic send_scalar(int unsigned chunks, bit retune);
		for (int unsigned k = 0; k < chunks; k++) begin
			if (retune && k > 0 && k == chunks / 2) begin
				drain_results();
				write_window(W_W'($urandom_range(0, 7)));
			end
			send_chunk(chunk_pattern(), k == chunks - 1);
		end
	endtask

	initial begin : stimulus
		logic [W_W-1:0] phase_windows [10] = '{3'd2, 3'd7, 3'd3, 3'd0, 3'd5,
			3'd6, 3'd1, 3'd4, 3'd7, 3'd2};
		calm = 0;
		hold_off_request = 0;
		@(posedge arst_n);
		@(posedge clk);

		// Directed, reset window (w = 4) first.
		send_chunk(32'h0000_0000, 1'b1);	// zero scalar: summary only
		send_chunk(32'hFFFF_FFFF, 1'b1);	// all ones, carry flushed past the chunk
		send_chunk(32'h0000_0001, 1'b1);
		send_chunk(32'h8000_0000, 1'b1);	// lone top bit
		send_chunk(32'hAAAA_AAAA, 1'b0);
		send_chunk(32'h5555_5555, 1'b1);
		send_chunk(32'hFFFF_FFFF, 1'b0);	// carry runs across the chunk boundary
		send_chunk(32'hFFFF_FFFF, 1'b1);
		drain_results();

		// Widest window: largest magnitudes of both signs.
		write_window(3'd7);
		send_chunk(32'hFFFF_FFFF, 1'b1);
		send_chunk(32'h0000_003F, 1'b1);	// digit +63
		send_chunk(32'h0000_0041, 1'b1);	// digit -63
		drain_results();

		// Widen mid scalar.
		write_window(3'd2);
		send_chunk(32'h1234_5677, 1'b0);
		drain_results();
		write_window(3'd6);
		send_chunk(32'hDEAD_BEEF, 1'b1);
		drain_results();

		// Narrow mid scalar with six bits held: surplus decides before new bits.
		write_window(3'd7);
		send_chunk(32'hF000_0000, 1'b0);
		drain_results();
		write_window(3'd2);
		send_chunk(32'h0000_0005, 1'b1);
		drain_results();

		// Random phases, one window setting each; the first one also holds off
		// the receiver long enough to back the block up into its input.
		foreach (phase_windows[p]) begin
			write_window(phase_windows[p]);
			calm = (p != 0) && ($urandom_range(0, 3) == 0);
			if (p == 0) hold_off_request = 1;
			repeat (6) send_scalar($urandom_range(1, 4), $urandom_range(0, 2) == 0);
			drain_results();

			// At w = 2 an all-ones scalar of exactly the position limit carries
			// into position 1024, which is still reported.
			if (p == 0) begin
				for (int k = 0; k < MAX_POSITIONS / CHUNK_BITS; k++)
					send_chunk('1, k == MAX_POSITIONS / CHUNK_BITS - 1);
				drain_results();
			end
			// Past the limit: overflow, digits beyond it dropped.
			if (p == 4) begin
				send_scalar(MAX_POSITIONS / CHUNK_BITS + 2, 1'b0);
				drain_results();
			end
		end

		if (naf_board.errors == 0 && naf_board.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
